// ===== sv/fohrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fohrq_pkg - shared types and codes of the request queue
// Word layouts of the request and response channels, the stored entry,
// command, policy and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package fohrq_pkg;

	// default number of entries
	localparam int DEFAULT_DEPTH = 16;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_SFF  = 1'b1;

	// response status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// request word
	typedef struct packed {
		logic        cmd;
		logic [15:0] handle;
		logic [31:0] name_ref;
		logic [31:0] size_bytes;
	} req_word_t;

	// response word
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_handle;
		logic [31:0] out_name_ref;
		logic [31:0] out_size;
		logic [4:0]  occupancy;
	} rsp_word_t;

	// one stored request
	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] name_ref;
		logic [31:0] size_bytes;
	} entry_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_FIFO_RD,
		S_POP,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/fifo_or_min_heap_request_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_or_min_heap_request_queue_core - bounded request queue
// Holds up to DEPTH requests, served either first in first out (circular
// buffer) or smallest file size first (array min-heap with one compare unit
// for sift down and one for sift up, walking the tree one level at a time).
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------
//  req     | in        | req_valid/req_ready  | cmd, handle, name, size
//  rsp     | out       | rsp_valid/rsp_ready  | status, removed entry, occ
//  cfg     | in        | cfg_valid/cfg_ready  | policy bit
//
//  States from taking a word to its response: FIFO insert START; FIFO remove
//  START, FIFO_RD; refused command START; heap insert START, then UP_RD and
//  UP_CMP per level climbed; heap remove START, POP, then DN_RD and DN_CMP
//  per level sunk; each ends in DONE. The memory has a single write port.
//  Reset clears pointers, count and policy; the entry memory is not cleared.
//  A result waits in the done state while the output register is held; the
//  next word is taken once the sequencer is back in the idle state.
// ----------------------------------------------------------------------------
module fifo_or_min_heap_request_queue_core
	import fohrq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
	localparam logic [4:0]    OCC_FULL   = 5'(DEPTH);

	// entry memory
	entry_t mem [DEPTH];

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   tail_q, tail_d;
	logic [AW-1:0]   pos_q, pos_d;
	logic            policy_q, policy_d;
	logic            cmd_q, cmd_d;
	entry_t          item_q, item_d;
	rsp_word_t       res_q, res_d;
	rsp_word_t       rsp_q, rsp_d;
	logic            rsp_valid_q, rsp_valid_d;

	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	entry_t          mem_wd;
	logic [AW-1:0]   rd_addr_a, rd_addr_b;
	entry_t          rd_a_q, rd_b_q;

	logic [AW-1:0]   parent_idx;
	logic [IW-1:0]   left_idx, right_idx, count_ext;
	logic            left_in, right_in, take_left, take_right;
	logic [31:0]     small_key;
	logic [CW+4:0]   occ_wide;
	logic [CW-1:0]   fifo_fill;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// heap index arithmetic
	assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = IW'({1'b0, pos_q, 1'b0} + IW'(2));
	assign count_ext  = IW'(count_q);
	assign left_in    = left_idx < count_ext;
	assign right_in   = right_idx < count_ext;

	// compare unit for sift down: right child first, then left
	assign take_right = right_in && (rd_b_q.size_bytes < item_q.size_bytes);
	assign small_key  = take_right ? rd_b_q.size_bytes : item_q.size_bytes;
	assign take_left  = left_in && (rd_a_q.size_bytes < small_key);

	assign occ_wide = {5'b0, count_q};

	// fifo fill level from pointers
	assign fifo_fill = (tail_q >= head_q) ? CW'(tail_q - head_q)
		: CW'(COUNT_FULL + CW'(tail_q) - CW'(head_q));

	// memory write and registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			policy_q    <= POLICY_FIFO;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			policy_q    <= policy_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		cmd_q  <= cmd_d;
		item_q <= item_d;
		res_q  <= res_d;
		rsp_q  <= rsp_d;
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		head_d      = head_q;
		tail_d      = tail_q;
		pos_d       = pos_q;
		policy_d    = policy_q;
		cmd_d       = cmd_q;
		item_d      = item_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q;
		mem_we      = 1'b0;
		mem_wa      = pos_q;
		mem_wd      = item_q;
		rd_addr_a   = parent_idx;
		rd_addr_b   = '0;

		// response word leaves
		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		// policy write, a change flushes the queue
		if (cfg_valid && cfg_ready) begin
			policy_d = cfg_data;
			if (cfg_data != policy_q) begin
				count_d = '0;
				head_d  = '0;
				tail_d  = '0;
			end
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_d  = req.cmd;
					item_d = '{handle: req.handle, name_ref: req.name_ref,
						size_bytes: req.size_bytes};
					state_d = S_START;
				end
			end

			S_START: begin
				res_d = '0;
				res_d.status = STATUS_DONE;
				if (cmd_q == CMD_INSERT) begin
					if (count_q == COUNT_FULL) begin
						res_d.status = STATUS_FULL;
						state_d = S_DONE;
					end else if (policy_q == POLICY_FIFO) begin
						mem_we  = 1'b1;
						mem_wa  = tail_q;
						tail_d  = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
						count_d = count_q + CW'(1);
						state_d = S_DONE;
					end else begin
						pos_d   = AW'(count_q);
						count_d = count_q + CW'(1);
						state_d = S_UP_RD;
					end
				end else begin
					if (count_q == '0) begin
						res_d.status = STATUS_EMPTY;
						state_d = S_DONE;
					end else if (policy_q == POLICY_FIFO) begin
						rd_addr_a = head_q;
						state_d   = S_FIFO_RD;
					end else begin
						rd_addr_a = '0;
						rd_addr_b = AW'(count_q - CW'(1));
						state_d   = S_POP;
					end
				end
			end

			S_FIFO_RD: begin
				res_d.out_handle   = rd_a_q.handle;
				res_d.out_name_ref = rd_a_q.name_ref;
				res_d.out_size     = rd_a_q.size_bytes;
				head_d  = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
				count_d = count_q - CW'(1);
				state_d = S_DONE;
			end

			// root leaves, last entry becomes the hole's item
			S_POP: begin
				res_d.out_handle   = rd_a_q.handle;
				res_d.out_name_ref = rd_a_q.name_ref;
				res_d.out_size     = rd_a_q.size_bytes;
				item_d  = rd_b_q;
				count_d = count_q - CW'(1);
				pos_d   = '0;
				state_d = S_DN_RD;
			end

			// sift up: fetch parent or settle at the root
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					rd_addr_a = parent_idx;
					state_d   = S_UP_CMP;
				end
			end

			S_UP_CMP: begin
				mem_we = 1'b1;
				if (rd_a_q.size_bytes > item_q.size_bytes) begin
					mem_wd  = rd_a_q;
					pos_d   = parent_idx;
					state_d = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			// sift down: fetch both children
			S_DN_RD: begin
				rd_addr_a = left_idx[AW-1:0];
				rd_addr_b = right_idx[AW-1:0];
				state_d   = S_DN_CMP;
			end

			S_DN_CMP: begin
				mem_we = 1'b1;
				if (take_left) begin
					mem_wd  = rd_a_q;
					pos_d   = left_idx[AW-1:0];
					state_d = S_DN_RD;
				end else if (take_right) begin
					mem_wd  = rd_b_q;
					pos_d   = right_idx[AW-1:0];
					state_d = S_DN_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			// hand the result to the output register
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d           = res_q;
					rsp_d.occupancy = occ_wide[4:0];
					rsp_valid_d     = 1'b1;
					state_d         = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("entry count above depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STATUS_FULL) |-> rsp_q.occupancy == OCC_FULL)
		else $error("full refusal with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STATUS_EMPTY) |->
			(rsp_q.occupancy == 5'd0 && rsp_q.out_size == 32'd0 &&
			rsp_q.out_handle == 16'd0))
		else $error("empty refusal with data or occupancy");

	a_fifo_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && policy_q == POLICY_FIFO && count_q != COUNT_FULL) |->
			fifo_fill == count_q)
		else $error("fifo pointers disagree with count");

endmodule
`default_nettype wire

// ===== verif/request_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_queue_checker - response predictor and compare for the request queue
// Watches the policy, request and response channels of the queue. Keeps its
// own copy of the entry store, pointers, count and policy, works out the
// response of every accepted request word, and compares each accepted response
// word field by field against the oldest response still due.
// ----------------------------------------------------------------------------
module request_queue_checker
	import fohrq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_ready,
	input  wire req_word_t req,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_ready,
	input  wire rsp_word_t rsp,
	input  wire logic      cfg_valid,
	input  wire logic      cfg_ready,
	input  wire logic      cfg_data,
	output int             mismatches,
	output int             pending
);

	// shadow copy of the queue
	entry_t    slot_mem [DEPTH];
	int        rd_slot;
	int        wr_slot;
	int        held;
	logic      policy_q;
	rsp_word_t due_rsp_q [$];
	rsp_word_t want;

	// swap two heap slots
	task automatic swap_slots(input int a, input int b);
		entry_t t;
		t = slot_mem[a];
		slot_mem[a] = slot_mem[b];
		slot_mem[b] = t;
	endtask

	// apply one request word to the shadow queue and form its response
	task automatic serve_request(input req_word_t w, output rsp_word_t r);
		int   pos;
		int   par;
		int   lft;
		int   rgt;
		int   low;
		logic settled;
		r = '0;
		if (w.cmd == CMD_INSERT) begin
			if (held >= DEPTH) begin
				r.status = STATUS_FULL;
			end else if (policy_q == POLICY_FIFO) begin
				slot_mem[wr_slot] = {w.handle, w.name_ref, w.size_bytes};
				wr_slot = (wr_slot + 1) % DEPTH;
				held++;
			end else begin
				// append, then climb while the parent is strictly larger
				pos = held;
				slot_mem[pos] = {w.handle, w.name_ref, w.size_bytes};
				held++;
				settled = 1'b0;
				while (!settled && pos > 0) begin
					par = (pos - 1) / 2;
					if (slot_mem[par].size_bytes > slot_mem[pos].size_bytes) begin
						swap_slots(par, pos);
						pos = par;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end else begin
			if (held == 0) begin
				r.status = STATUS_EMPTY;
			end else if (policy_q == POLICY_FIFO) begin
				r.out_handle   = slot_mem[rd_slot].handle;
				r.out_name_ref = slot_mem[rd_slot].name_ref;
				r.out_size     = slot_mem[rd_slot].size_bytes;
				rd_slot = (rd_slot + 1) % DEPTH;
				held--;
			end else begin
				// take the root, move the last entry up, sink it (right child first)
				r.out_handle   = slot_mem[0].handle;
				r.out_name_ref = slot_mem[0].name_ref;
				r.out_size     = slot_mem[0].size_bytes;
				slot_mem[0] = slot_mem[held - 1];
				held--;
				pos = 0;
				settled = 1'b0;
				while (!settled) begin
					lft = 2 * pos + 1;
					rgt = 2 * pos + 2;
					low = pos;
					if (rgt < held && slot_mem[rgt].size_bytes < slot_mem[low].size_bytes)
						low = rgt;
					if (lft < held && slot_mem[lft].size_bytes < slot_mem[low].size_bytes)
						low = lft;
					if (low == pos) begin
						settled = 1'b1;
					end else begin
						swap_slots(pos, low);
						pos = low;
					end
				end
			end
		end
		r.occupancy = 5'(held);
	endtask

	// count a failure, print the first few
	task automatic flag(input string what, input rsp_word_t exp_w, input rsp_word_t got);
		if (mismatches < 10)
			$display("%0t %s: want st=%0d h=%h n=%h sz=%h occ=%0d got st=%0d h=%h n=%h sz=%h occ=%0d",
				$time, what, exp_w.status, exp_w.out_handle, exp_w.out_name_ref,
				exp_w.out_size, exp_w.occupancy, got.status, got.out_handle,
				got.out_name_ref, got.out_size, got.occupancy);
		mismatches++;
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot  = 0;
			wr_slot  = 0;
			held     = 0;
			policy_q = POLICY_FIFO;
			due_rsp_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// policy write; a change of value flushes the queue
			if (cfg_valid && cfg_ready) begin
				if (cfg_data !== policy_q) begin
					held    = 0;
					rd_slot = 0;
					wr_slot = 0;
				end
				policy_q = cfg_data;
			end
			// request word taken
			if (req_valid && req_ready) begin
				serve_request(req, want);
				due_rsp_q.push_back(want);
			end
			// response word taken
			if (rsp_valid && rsp_ready) begin
				if (due_rsp_q.size() == 0) begin
					flag("unexpected response", '0, rsp);
				end else begin
					want = due_rsp_q.pop_front();
					if (rsp.status !== want.status || rsp.out_handle !== want.out_handle ||
					    rsp.out_name_ref !== want.out_name_ref ||
					    rsp.out_size !== want.out_size || rsp.occupancy !== want.occupancy)
						flag("response mismatch", want, rsp);
				end
			end
			pending = due_rsp_q.size();
		end
	end

endmodule

// ===== verif/tb_fifo_or_min_heap_request_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_or_min_heap_request_queue_core - testbench of the request queue
// Drives request words and policy writes into the queue, with random gaps on
// the sender and random stalls on the receiver, while the checker predicts
// and compares every response. Directed words cover empty and full refusals,
// field extremes, ties in the heap and a policy flip with entries held; then
// random words run under both policies with phases of insert-heavy,
// balanced and remove-heavy traffic.
// ----------------------------------------------------------------------------
module tb_fifo_or_min_heap_request_queue_core;
	import fohrq_pkg::*;

	localparam int DEPTH     = DEFAULT_DEPTH;
	localparam int LIMIT     = 400000;
	localparam int SEG_WORDS = 265;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;

	int mismatches;
	int pending;
	int cycle_cnt    = 0;
	int req_idle_pct = 27;
	int rsp_idle_pct = 84;

	fifo_or_min_heap_request_queue_core #(.DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	request_queue_checker #(.DEPTH(DEPTH)) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("[fifo_or_min_heap_request_queue_core] ERROR");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
	end

	function automatic req_word_t mk_req(input logic cmd, input logic [15:0] h,
	                                     input logic [31:0] nm, input logic [31:0] sz);
		req_word_t w;
		w.cmd        = cmd;
		w.handle     = h;
		w.name_ref   = nm;
		w.size_bytes = sz;
		return w;
	endfunction

	// random word; sizes lean toward small values so the heap sees ties
	function automatic req_word_t rand_req(input int insert_pct);
		logic [31:0] sz;
		case ($urandom_range(3))
			0:       sz = $urandom_range(7);
			1:       sz = $urandom_range(255);
			2:       sz = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: sz = $urandom;
		endcase
		return mk_req(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
			16'($urandom_range(65535)), $urandom, sz);
	endfunction

	// send one request word, with random gaps before it
	task automatic push_req(input req_word_t w);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// let every response come back, then write the policy bit
	task automatic set_policy(input logic p);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= p;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		int seg;
		int i;
		int ins_pct;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fifo: same-value write, empty remove, fill with extremes, full insert, two removes
		set_policy(POLICY_FIFO);
		push_req(mk_req(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (i = 0; i < DEPTH; i++)
			push_req(mk_req(CMD_INSERT, i[0] ? 16'(16'hFFFF - i) : 16'(i),
				i[0] ? ~32'(i) : 32'(i), i[1] ? 32'hFFFF_FFFF - i : 32'(i)));
		push_req(mk_req(CMD_INSERT, 16'h1234, 32'h5678_9ABC, 32'h1));
		push_req(mk_req(CMD_REMOVE, 16'h0, 32'h0, 32'h0));
		push_req(mk_req(CMD_REMOVE, 16'h0, 32'h0, 32'h0));

		// flip to smallest-first with entries held: queue flushes
		set_policy(POLICY_SFF);
		push_req(mk_req(CMD_REMOVE, 16'h0, 32'h0, 32'h0));
		push_req(mk_req(CMD_INSERT, 16'hAAAA, 32'h1111_1111, 32'hFFFF_FFFF));
		push_req(mk_req(CMD_INSERT, 16'h5555, 32'h2222_2222, 32'd5));
		push_req(mk_req(CMD_INSERT, 16'h0001, 32'h3333_3333, 32'd5));
		push_req(mk_req(CMD_INSERT, 16'h0002, 32'h4444_4444, 32'd0));
		push_req(mk_req(CMD_REMOVE, 16'h0, 32'h0, 32'h0));
		push_req(mk_req(CMD_REMOVE, 16'h0, 32'h0, 32'h0));

		// random segments across policies and idle modes
		for (seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				req_idle_pct = 84;
				rsp_idle_pct = 27;
			end else if (seg == 4) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			set_policy((seg == 1 || seg == 3) ? POLICY_FIFO : POLICY_SFF);
			ins_pct = 50;
			for (i = 0; i < SEG_WORDS; i++) begin
				if (i % 24 == 0) begin
					case ($urandom_range(2))
						0:       ins_pct = 20;
						1:       ins_pct = 50;
						default: ins_pct = 80;
					endcase
				end
				push_req(rand_req(ins_pct));
			end
		end

		// drain and settle
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		if (mismatches == 0 && pending == 0)
			$display("[fifo_or_min_heap_request_queue_core] OK");
		else
			$display("[fifo_or_min_heap_request_queue_core] ERROR");
		$finish;
	end

endmodule
